FILE: rtl/bitwise_marginal_estimator_unit_defines.svh
`ifndef BITWISE_MARGINAL_ESTIMATOR_UNIT_DEFINES_SVH
`define BITWISE_MARGINAL_ESTIMATOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define BMEST_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define BMEST_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/bmest_pkg.sv
package bmest_pkg;

	localparam int IN_W = 64;
	localparam int CNT_W = 11;
	localparam int DIM_W = 7;
	localparam int POS_W = 6;
	localparam int FRAC_W = 16;
	localparam int PROB_W = FRAC_W + 1;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;
	localparam int STEP_W = 5;

	localparam logic [STEP_W-1:0] DIV_LAST_STEP = STEP_W'(FRAC_W + 1);
	localparam logic [PROB_W-1:0] ONE_Q16 = PROB_W'(1) << FRAC_W;

	localparam logic REG_PARENT_COUNT = 1'b0;
	localparam logic REG_DIMENSION = 1'b1;

	// Lower probability bound 65536 / n, indexed by n - 1.
	localparam logic [PROB_W-1:0] LOWER_Q16 [64] = '{
		17'd65536, 17'd32768, 17'd21845, 17'd16384, 17'd13107, 17'd10922, 17'd9362,
		17'd8192, 17'd7281, 17'd6553, 17'd5957, 17'd5461, 17'd5041, 17'd4681,
		17'd4369, 17'd4096, 17'd3855, 17'd3640, 17'd3449, 17'd3276, 17'd3120,
		17'd2978, 17'd2849, 17'd2730, 17'd2621, 17'd2520, 17'd2427, 17'd2340,
		17'd2259, 17'd2184, 17'd2114, 17'd2048, 17'd1985, 17'd1927, 17'd1872,
		17'd1820, 17'd1771, 17'd1724, 17'd1680, 17'd1638, 17'd1598, 17'd1560,
		17'd1524, 17'd1489, 17'd1456, 17'd1424, 17'd1394, 17'd1365, 17'd1337,
		17'd1310, 17'd1285, 17'd1260, 17'd1236, 17'd1213, 17'd1191, 17'd1170,
		17'd1149, 17'd1129, 17'd1110, 17'd1092, 17'd1074, 17'd1057, 17'd1040,
		17'd1024
	};

	typedef struct packed {
		logic add;
		logic init;
		logic step;
		logic finish;
		logic shift;
	} bmest_cmd_t;

endpackage

FILE: rtl/bitwise_marginal_estimator_unit.sv
// Counts the ones at each bit position over the first parent_count parents of a set, one
// parent per cycle while the input is not stalled, with every position counted in its own
// cell of a chain. Bits at and above the current dimension are not counted. A parent
// marked last closes the set: the input then stalls while all cells divide their counts
// by parent_count in parallel, sixteen quotient bits at one per cycle. The chain then
// shifts the probabilities toward the output register, one result per cycle while the
// output is not stalled, in ascending position order, clamped to the range
// [65536/n, 65536 - 65536/n] with the lower bound taking precedence. The input stays
// stalled until the last result is loaded, and the next set may start while it still waits.
`include "bitwise_marginal_estimator_unit_defines.svh"

module bitwise_marginal_estimator_unit #(
	parameter int MAX_BITS = 64,
	parameter int MAX_PARENTS = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bmest_pkg::ADDR_W-1:0] paddr,
	input  logic [bmest_pkg::DATA_W-1:0] pwdata,
	output logic [bmest_pkg::DATA_W-1:0] prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [bmest_pkg::IN_W-1:0]   parent_bits,
	input  logic                         last_parent,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [bmest_pkg::POS_W-1:0]  position,
	output logic [bmest_pkg::PROB_W-1:0] probability,
	output logic                         last_position
);
	import bmest_pkg::*;

	typedef enum logic [1:0] {ST_ACC, ST_DIV, ST_OUT} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  parent_count_q;
	logic [DIM_W-1:0]  dimension_q;
	logic [CNT_W-1:0]  parents_seen_q;
	logic [STEP_W-1:0] step_q;
	logic [POS_W-1:0]  pos_q;
	logic [CNT_W-1:0]  mu_q;
	logic [DIM_W-1:0]  n_q;
	logic [PROB_W-1:0] lower_q;
	logic [PROB_W-1:0] upper_q;
	logic              out_valid_q;
	logic [POS_W-1:0]  position_q;
	logic [PROB_W-1:0] probability_q;
	logic              last_position_q;

	logic [CNT_W-1:0]  mu_eff;
	logic [DIM_W-1:0]  n_eff;
	logic [PROB_W-1:0] lower_eff;
	logic              in_acc;
	logic              count_ok;
	logic              out_load;
	logic              pos_last;
	logic [PROB_W-1:0] prob_hi;
	logic [PROB_W-1:0] prob_clamped;
	bmest_cmd_t        cmd;

	logic [PROB_W-1:0] cell_prob [MAX_BITS];
	logic [PROB_W-1:0] next_prob [MAX_BITS];
	logic [MAX_BITS-1:0] bit_en;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parent_count_q <= CNT_W'(1);
			dimension_q <= DIM_W'(64);
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_PARENT_COUNT: parent_count_q <= pwdata[CNT_W-1:0];
				REG_DIMENSION:    dimension_q <= pwdata[DIM_W-1:0];
				default:          ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_PARENT_COUNT: prdata = {{(DATA_W-CNT_W){1'b0}}, parent_count_q};
			REG_DIMENSION:    prdata = {{(DATA_W-DIM_W){1'b0}}, dimension_q};
			default:          prdata = '0;
		endcase
	end

	always_comb begin
		if (parent_count_q == '0) begin
			mu_eff = CNT_W'(1);
		end else if (32'(parent_count_q) > MAX_PARENTS) begin
			mu_eff = CNT_W'(MAX_PARENTS);
		end else begin
			mu_eff = parent_count_q;
		end
		if (dimension_q == '0) begin
			n_eff = DIM_W'(1);
		end else if (32'(dimension_q) > MAX_BITS) begin
			n_eff = DIM_W'(MAX_BITS);
		end else begin
			n_eff = dimension_q;
		end
	end

	assign lower_eff = LOWER_Q16[POS_W'(n_eff - 1'b1)];

	assign in_stall = (state_q != ST_ACC);
	assign in_acc = in_valid && !in_stall;
	assign count_ok = parents_seen_q < mu_eff;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall);
	assign pos_last = ({1'b0, pos_q} == (n_q - 1'b1));

	always_comb begin
		cmd.add = in_acc && count_ok;
		cmd.init = (state_q == ST_DIV) && (step_q == '0);
		cmd.step = (state_q == ST_DIV) && (step_q != '0) && (step_q != DIV_LAST_STEP);
		cmd.finish = (state_q == ST_DIV) && (step_q == DIV_LAST_STEP);
		cmd.shift = out_load;
	end

	for (genvar i = 0; i < MAX_BITS; i++) begin : g_cell
		if (i == MAX_BITS - 1) begin : g_end
			assign next_prob[i] = '0;
		end else begin : g_mid
			assign next_prob[i] = cell_prob[i+1];
		end

		assign bit_en[i] = parent_bits[i] && (DIM_W'(i) < n_eff);

		bmest_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.bit_in    (bit_en[i]),
			.mu        (mu_q),
			.next_prob (next_prob[i]),
			.prob      (cell_prob[i])
		);
	end

	assign prob_hi = (cell_prob[0] > upper_q) ? upper_q : cell_prob[0];
	assign prob_clamped = (prob_hi < lower_q) ? lower_q : prob_hi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
			parents_seen_q <= '0;
			step_q <= '0;
			pos_q <= '0;
			mu_q <= CNT_W'(1);
			n_q <= DIM_W'(1);
			lower_q <= '0;
			upper_q <= '0;
			out_valid_q <= 1'b0;
			position_q <= '0;
			probability_q <= '0;
			last_position_q <= 1'b0;
		end else begin
			case (state_q)
				ST_ACC: begin
					if (in_acc) begin
						if (last_parent) begin
							state_q <= ST_DIV;
							parents_seen_q <= '0;
							step_q <= '0;
							mu_q <= mu_eff;
							n_q <= n_eff;
							lower_q <= lower_eff;
							upper_q <= ONE_Q16 - lower_eff;
						end else if (count_ok) begin
							parents_seen_q <= parents_seen_q + 1'b1;
						end
					end
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == DIV_LAST_STEP) begin
						state_q <= ST_OUT;
						pos_q <= '0;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						pos_q <= pos_q + 1'b1;
						if (pos_last) begin
							state_q <= ST_ACC;
						end
					end
				end
				default: state_q <= ST_ACC;
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
				position_q <= pos_q;
				probability_q <= prob_clamped;
				last_position_q <= pos_last;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign position = position_q;
	assign probability = probability_q;
	assign last_position = last_position_q;

	`BMEST_ASSERT_NEXT(a_last_stalls, in_valid && !in_stall && last_parent, in_stall, "Input not stalled after the last parent of a set.")
	`BMEST_ASSERT_NEXT(a_pos_sequence, out_valid && !out_stall && !last_position, out_valid && (position == $past(position) + 1'b1), "Result positions did not follow in order.")
	`BMEST_ASSERT_IMPLIES(a_seen_clear, state_q != ST_ACC, parents_seen_q == '0, "Parent count not cleared while results are produced.")

endmodule

FILE: rtl/bmest_cell.sv
module bmest_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bmest_pkg::bmest_cmd_t        cmd,
	input  logic                         bit_in,
	input  logic [bmest_pkg::CNT_W-1:0]  mu,
	input  logic [bmest_pkg::PROB_W-1:0] next_prob,
	output logic [bmest_pkg::PROB_W-1:0] prob
);
	import bmest_pkg::*;

	logic [CNT_W-1:0]  cnt_q;
	logic [PROB_W-1:0] quo_q;
	logic              big_q;
	logic [CNT_W:0]    rem2;
	logic              fits;

	// The count register doubles as the partial remainder during division.
	assign rem2 = {cnt_q, 1'b0};
	assign fits = rem2 >= {1'b0, mu};
	assign prob = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.add && bit_in) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (cmd.step) begin
			if (fits) begin
				cnt_q <= CNT_W'(rem2 - {1'b0, mu});
			end else begin
				cnt_q <= rem2[CNT_W-1:0];
			end
		end else if (cmd.finish) begin
			cnt_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			quo_q <= '0;
			big_q <= cnt_q >= mu;
		end else if (cmd.step) begin
			quo_q <= {quo_q[PROB_W-2:0], fits};
		end else if (cmd.finish) begin
			if (big_q) begin
				quo_q <= ONE_Q16;
			end
		end else if (cmd.shift) begin
			quo_q <= next_prob;
		end
	end

endmodule

FILE: tb/bitwise_marginal_estimator_unit_tb.sv
`timescale 1ns / 1ps

module bitwise_marginal_estimator_unit_tb;

	localparam int DIRECTED_ITEMS = 23;
	localparam int TOTAL_ITEMS = 300;
	localparam int SETTLE_CYCLES = 40;
	localparam int TAIL_CYCLES = 100;
	localparam int IDLE_LIMIT = 5000;

	typedef struct {
		logic [bmest_pkg::IN_W-1:0] bits;
		logic                       last;
	} parent_item_t;

	typedef struct {
		logic [bmest_pkg::POS_W-1:0]  pos;
		logic [bmest_pkg::PROB_W-1:0] prob;
		logic                         last;
	} marginal_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [bmest_pkg::ADDR_W-1:0] paddr = '0;
	logic [bmest_pkg::DATA_W-1:0] pwdata = '0;
	logic [bmest_pkg::DATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [bmest_pkg::IN_W-1:0] parent_bits = '0;
	logic last_parent = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [bmest_pkg::POS_W-1:0] position;
	logic [bmest_pkg::PROB_W-1:0] probability;
	logic last_position;

	parent_item_t parent_feed_q[$];
	marginal_t marginal_expect_q[$];
	int parents_queued = 0;
	int parents_taken = 0;
	int mismatches = 0;
	int idle_cycles = 0;
	int in_gap_left = 0;
	int out_stall_left = 0;
	logic no_idle = 1'b0;

	logic [10:0] cfg_parents = 11'd1;
	logic [6:0] cfg_dim = 7'd64;
	logic [10:0] ones_cnt [64];
	logic [10:0] seen_cnt = '0;

	bitwise_marginal_estimator_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.parent_bits(parent_bits),
		.last_parent(last_parent),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.position(position),
		.probability(probability),
		.last_position(last_position)
	);

	always #2 clk = ~clk;

	function automatic int eff_parents(input logic [10:0] v);
		if (v == 0)
			return 1;
		if (v > 1024)
			return 1024;
		return int'(v);
	endfunction

	function automatic int eff_dim(input logic [6:0] v);
		if (v == 0)
			return 1;
		if (v > 64)
			return 64;
		return int'(v);
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	function automatic logic [63:0] rand_parent();
		logic [63:0] a;
		logic [63:0] b;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0: return '1;
			1: return '0;
			2: return a & b & {$urandom, $urandom};
			3: return a | b;
			default: return a;
		endcase
	endfunction

	task automatic estimate_marginals(input logic [63:0] bits, input logic last);
		int mu;
		int n;
		logic [63:0] scaled;
		logic [16:0] lo;
		logic [16:0] hi;
		marginal_t r;
		mu = eff_parents(cfg_parents);
		n = eff_dim(cfg_dim);
		if (seen_cnt < mu) begin
			for (int i = 0; i < n; i++)
				if (bits[i])
					ones_cnt[i] = ones_cnt[i] + 11'd1;
			seen_cnt = seen_cnt + 11'd1;
		end
		if (last) begin
			lo = 17'(65536 / n);
			hi = 17'd65536 - lo;
			for (int i = 0; i < n; i++) begin
				scaled = (64'(ones_cnt[i]) << 16) / 64'(mu);
				if (scaled > 64'(hi))
					scaled = 64'(hi);
				if (scaled < 64'(lo))
					scaled = 64'(lo);
				r.pos = 6'(i);
				r.prob = scaled[16:0];
				r.last = (i == n - 1);
				marginal_expect_q.insert(marginal_expect_q.size(), r);
			end
			for (int i = 0; i < 64; i++)
				ones_cnt[i] = '0;
			seen_cnt = '0;
		end
	endtask

	task automatic push_parent(input logic [63:0] bits, input logic last);
		parent_item_t it;
		it.bits = bits;
		it.last = last;
		parent_feed_q.insert(parent_feed_q.size(), it);
		parents_queued++;
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == bmest_pkg::REG_PARENT_COUNT)
			cfg_parents = value[10:0];
		else
			cfg_dim = value[6:0];
	endtask

	task automatic settle();
		while (parents_taken != parents_queued || marginal_expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Builds one set for the current settings: for mu above 24 one to six parents, else mostly
	// exactly mu, sometimes short or overlong; now and then with random last marks as noise.
	task automatic push_set(output int count);
		int mu;
		int len;
		int r;
		logic noisy;
		mu = eff_parents(cfg_parents);
		r = $urandom_range(0, 99);
		noisy = ($urandom_range(0, 9) == 0);
		if (mu > 24)
			len = $urandom_range(1, 6);
		else if (r < 70 || (r < 85 && mu == 1))
			len = mu;
		else if (r < 85)
			len = $urandom_range(1, mu - 1);
		else
			len = mu + $urandom_range(1, 4);
		for (int i = 0; i < len; i++) begin
			if (noisy)
				push_parent(rand_parent(), 1'($urandom_range(0, 1)));
			else
				push_parent(rand_parent(), i == len - 1);
		end
		count = len;
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap_left = 0;
		end else begin
			if (in_valid && !in_stall) begin
				estimate_marginals(parent_bits, last_parent);
				parents_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (in_gap_left > 0) begin
					in_gap_left--;
					in_valid <= 1'b0;
				end else if (parent_feed_q.size() > 0) begin
					in_valid <= 1'b1;
					parent_bits <= parent_feed_q[0].bits;
					last_parent <= parent_feed_q[0].last;
					void'(parent_feed_q.pop_front());
					in_gap_left = gap_len();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		marginal_t exp_r;
		if (!arst_n) begin
			out_stall <= 1'b0;
			idle_cycles = 0;
		end else begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)
					|| (psel && penable && pwrite && pready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (out_valid && !out_stall) begin
				if (marginal_expect_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: position %0d probability %0d last %0b",
							position, probability, last_position);
				end else begin
					exp_r = marginal_expect_q.pop_front();
					if (position !== exp_r.pos || probability !== exp_r.prob
							|| last_position !== exp_r.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected pos %0d prob %0d last %0b, got pos %0d prob %0d last %0b",
								exp_r.pos, exp_r.prob, exp_r.last,
								position, probability, last_position);
					end
				end
			end
			if (out_stall_left > 0) begin
				out_stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				out_stall_left = gap_len();
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL bitwise_marginal_estimator_unit");
				$finish;
			end
		end
	end

	initial begin
		int rand_items;
		int got;
		for (int i = 0; i < 64; i++)
			ones_cnt[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Settings after reset: one parent, all 64 positions, both clamps.
		push_parent('1, 1'b1);
		push_parent('0, 1'b1);
		push_parent('1, 1'b0);
		push_parent('0, 1'b1);
		settle();

		// Zero in both registers, so a single position with probability one.
		write_reg(bmest_pkg::REG_PARENT_COUNT, 32'd0);
		write_reg(bmest_pkg::REG_DIMENSION, 32'd0);
		push_parent({$urandom, $urandom}, 1'b1);
		push_parent('0, 1'b1);
		settle();

		// Saturated registers with a short set.
		write_reg(bmest_pkg::REG_PARENT_COUNT, 32'd2047);
		write_reg(bmest_pkg::REG_DIMENSION, 32'd127);
		push_parent('1, 1'b0);
		push_parent({$urandom, $urandom}, 1'b1);
		settle();

		// Bits above the dimension and a parent beyond mu.
		write_reg(bmest_pkg::REG_PARENT_COUNT, 32'd3);
		write_reg(bmest_pkg::REG_DIMENSION, 32'd5);
		push_parent(64'hFFFF_FFFF_FFFF_FFF5, 1'b0);
		push_parent(64'h0000_0000_0000_0007, 1'b0);
		push_parent(64'hAAAA_0000_5555_001F, 1'b0);
		push_parent('1, 1'b1);
		settle();

		write_reg(bmest_pkg::REG_PARENT_COUNT, 32'd1024);
		write_reg(bmest_pkg::REG_DIMENSION, 32'd1);
		push_parent('1, 1'b0);
		push_parent('1, 1'b1);
		settle();

		// Settings changed while a set is open.
		write_reg(bmest_pkg::REG_PARENT_COUNT, 32'd4);
		write_reg(bmest_pkg::REG_DIMENSION, 32'd2);
		push_parent('1, 1'b0);
		push_parent('1, 1'b0);
		settle();
		write_reg(bmest_pkg::REG_PARENT_COUNT, 32'd2);
		write_reg(bmest_pkg::REG_DIMENSION, 32'd64);
		push_parent('0, 1'b0);
		push_parent('1, 1'b1);
		settle();

		write_reg(bmest_pkg::REG_PARENT_COUNT, 32'd5);
		write_reg(bmest_pkg::REG_DIMENSION, 32'd63);
		for (int i = 0; i < 5; i++)
			push_parent({$urandom, $urandom}, i == 4);
		settle();

		rand_items = 0;
		while (DIRECTED_ITEMS + rand_items < TOTAL_ITEMS) begin
			no_idle = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 2) != 2) begin
				case ($urandom_range(0, 9))
					0: write_reg(bmest_pkg::REG_PARENT_COUNT, 32'd0);
					1: write_reg(bmest_pkg::REG_PARENT_COUNT, 32'($urandom_range(1025, 2047)));
					2: write_reg(bmest_pkg::REG_PARENT_COUNT, 32'($urandom_range(1000, 1024)));
					3: write_reg(bmest_pkg::REG_PARENT_COUNT, 32'd1);
					default: write_reg(bmest_pkg::REG_PARENT_COUNT, 32'($urandom_range(2, 12)));
				endcase
			end
			if ($urandom_range(0, 2) != 2) begin
				case ($urandom_range(0, 9))
					0: write_reg(bmest_pkg::REG_DIMENSION, 32'd0);
					1: write_reg(bmest_pkg::REG_DIMENSION, 32'($urandom_range(65, 127)));
					2: write_reg(bmest_pkg::REG_DIMENSION, 32'd1);
					3: write_reg(bmest_pkg::REG_DIMENSION, 32'd64);
					default: write_reg(bmest_pkg::REG_DIMENSION, 32'($urandom_range(1, 64)));
				endcase
			end
			repeat ($urandom_range(1, 4)) begin
				push_set(got);
				rand_items += got;
			end
			if ($urandom_range(0, 6) == 0) begin
				repeat ($urandom_range(1, 3)) begin
					push_parent(rand_parent(), 1'b0);
					rand_items++;
				end
			end
			settle();
		end

		while (parents_taken != parents_queued || marginal_expect_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (marginal_expect_q.size() != 0)
			mismatches++;
		if (mismatches == 0) begin
			$display("PASS bitwise_marginal_estimator_unit");
		end else begin
			$display("FAIL bitwise_marginal_estimator_unit");
		end
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/bmest_pkg.sv
rtl/bmest_cell.sv
rtl/bitwise_marginal_estimator_unit.sv
tb/bitwise_marginal_estimator_unit_tb.sv
